### rtl/hkrb_pkg.sv
package hkrb_pkg;

  // Number of key slot fields carried in every result.
  localparam int ReportSlots = 6;
  localparam int KeySlotsDefault = 6;

  localparam logic [7:0] RawBase = 8'd136;
  localparam logic [7:0] LeftShift = 8'h02;

  typedef enum logic [2:0] {
    CmdPress        = 3'd0,
    CmdRelease      = 3'd1,
    CmdWriteKey     = 3'd2,
    CmdReleaseAll   = 3'd3,
    CmdMediaPress   = 3'd4,
    CmdMediaRelease = 3'd5,
    CmdMediaWrite   = 3'd6
  } cmd_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [7:0]  key_code;
    logic [23:0] media_mask;
  } req_t;

  typedef struct packed {
    logic        report_kind;
    logic        report_sent;
    logic        accepted;
    logic [7:0]  modifier_bits;
    logic [7:0]  slot_key_0;
    logic [7:0]  slot_key_1;
    logic [7:0]  slot_key_2;
    logic [7:0]  slot_key_3;
    logic [7:0]  slot_key_4;
    logic [7:0]  slot_key_5;
    logic [23:0] media_bits;
    logic        last;
  } res_t;

  // ASCII to usage map. Bit 7 asks for left shift, zero means unmapped.
  localparam logic [7:0] AsciiUsage [128] = '{
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h2a, 8'h2b, 8'h28, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h2c, 8'h9e, 8'hb4, 8'ha0, 8'ha1, 8'ha2, 8'ha4, 8'h34,
    8'ha6, 8'ha7, 8'ha5, 8'hae, 8'h36, 8'h2d, 8'h37, 8'h38,
    8'h27, 8'h1e, 8'h1f, 8'h20, 8'h21, 8'h22, 8'h23, 8'h24,
    8'h25, 8'h26, 8'hb3, 8'h33, 8'hb6, 8'h2e, 8'hb7, 8'hb8,
    8'h9f, 8'h84, 8'h85, 8'h86, 8'h87, 8'h88, 8'h89, 8'h8a,
    8'h8b, 8'h8c, 8'h8d, 8'h8e, 8'h8f, 8'h90, 8'h91, 8'h92,
    8'h93, 8'h94, 8'h95, 8'h96, 8'h97, 8'h98, 8'h99, 8'h9a,
    8'h9b, 8'h9c, 8'h9d, 8'h2f, 8'h31, 8'h30, 8'ha3, 8'had,
    8'h35, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h0a,
    8'h0b, 8'h0c, 8'h0d, 8'h0e, 8'h0f, 8'h10, 8'h11, 8'h12,
    8'h13, 8'h14, 8'h15, 8'h16, 8'h17, 8'h18, 8'h19, 8'h1a,
    8'h1b, 8'h1c, 8'h1d, 8'haf, 8'hb1, 8'hb0, 8'hb5, 8'h00
  };

endpackage

### rtl/hid_keyboard_report_builder.sv
// Keyboard and media report builder.
// A request (command, key code, media mask) is taken at a rising edge with
// start_i high and busy_o low. The block holds the modifier mask, the key
// slots and the media mask, and every half of a command produces one result
// on res_o, marked by res_valid_o for exactly one cycle.
// Each request is registered in req_q and each result in res_q before it
// is on res_o; a result is taken at the edge that ends the cycle it is shown.
// Press, release, release all, media press and media release give one
// result, and a new request may follow in the next cycle. Write key and
// media write give two results on consecutive cycles; busy_o is high in
// the cycle after the request edge, so no new request is taken while the
// second half is pending. The rate is set by the single state update per
// cycle in the result stage.
// An unknown command gives no result and leaves the state unchanged.
// Reset clears the modifier mask, all key slots and the media mask and
// drops any pending request. The receiver cannot stall: each result is
// taken in the cycle it is shown.
module hid_keyboard_report_builder #(
  parameter int KeySlots = hkrb_pkg::KeySlotsDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  hkrb_pkg::req_t  req_i,
  output logic            busy_o,
  output logic            res_valid_o,
  output hkrb_pkg::res_t  res_o
);

  hkrb_pkg::req_t req_q;
  logic           req_valid_q, req_valid_d;
  logic           phase_q, phase_d;

  logic [7:0]     mod_q, mod_d;
  logic [7:0]     slots_q [KeySlots];
  logic [7:0]     slots_d [KeySlots];
  logic [23:0]    media_q, media_d;

  hkrb_pkg::res_t res_q, res_d;
  logic           res_valid_q, res_valid_d;

  logic           accept;
  logic           two_half;
  logic           pressing;
  logic [7:0]     key_mod;
  logic [7:0]     key_slots [KeySlots];
  logic           key_ok;
  logic [7:0]     out_slots [hkrb_pkg::ReportSlots];

  assign two_half = (req_q.cmd == hkrb_pkg::CmdWriteKey) ||
                    (req_q.cmd == hkrb_pkg::CmdMediaWrite);
  assign busy_o   = req_valid_q && two_half && !phase_q;
  assign accept   = start_i && !busy_o;
  assign pressing = (req_q.cmd == hkrb_pkg::CmdPress) ||
                    ((req_q.cmd == hkrb_pkg::CmdWriteKey) && !phase_q);

  hkrb_key_unit #(
    .KeySlots(KeySlots)
  ) u_key_unit (
    .pressing_i(pressing),
    .code_i    (req_q.key_code),
    .mod_i     (mod_q),
    .slots_i   (slots_q),
    .mod_o     (key_mod),
    .slots_o   (key_slots),
    .ok_o      (key_ok)
  );

  always_comb begin
    mod_d       = mod_q;
    slots_d     = slots_q;
    media_d     = media_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    if (req_valid_q) begin
      case (req_q.cmd)
        hkrb_pkg::CmdPress, hkrb_pkg::CmdRelease, hkrb_pkg::CmdWriteKey: begin
          mod_d             = key_mod;
          slots_d           = key_slots;
          res_valid_d       = 1'b1;
          res_d.report_kind = 1'b0;
          res_d.report_sent = key_ok;
          res_d.accepted    = key_ok;
        end
        hkrb_pkg::CmdReleaseAll: begin
          mod_d             = '0;
          slots_d           = '{default: '0};
          media_d           = '0;
          res_valid_d       = 1'b1;
          res_d.report_kind = 1'b0;
          res_d.report_sent = 1'b1;
          res_d.accepted    = 1'b1;
        end
        hkrb_pkg::CmdMediaPress, hkrb_pkg::CmdMediaRelease,
        hkrb_pkg::CmdMediaWrite: begin
          if (req_q.cmd == hkrb_pkg::CmdMediaRelease ||
              (req_q.cmd == hkrb_pkg::CmdMediaWrite && phase_q)) begin
            media_d = media_q & ~req_q.media_mask;
          end else begin
            media_d = media_q | req_q.media_mask;
          end
          res_valid_d       = 1'b1;
          res_d.report_kind = 1'b1;
          res_d.report_sent = 1'b1;
          res_d.accepted    = 1'b1;
        end
        default: begin
        end
      endcase
    end

    out_slots = '{default: '0};
    for (int i = 0; i < hkrb_pkg::ReportSlots && i < KeySlots; i++) begin
      out_slots[i] = slots_d[i];
    end
    res_d.modifier_bits = mod_d;
    res_d.slot_key_0    = out_slots[0];
    res_d.slot_key_1    = out_slots[1];
    res_d.slot_key_2    = out_slots[2];
    res_d.slot_key_3    = out_slots[3];
    res_d.slot_key_4    = out_slots[4];
    res_d.slot_key_5    = out_slots[5];
    res_d.media_bits    = media_d;
    res_d.last          = !two_half || phase_q;
  end

  // A two-half request stays in place for its second half.
  always_comb begin
    if (busy_o) begin
      phase_d     = 1'b1;
      req_valid_d = 1'b1;
    end else begin
      phase_d     = 1'b0;
      req_valid_d = accept;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      phase_q     <= 1'b0;
      res_valid_q <= 1'b0;
      mod_q       <= '0;
      slots_q     <= '{default: '0};
      media_q     <= '0;
    end else begin
      req_valid_q <= req_valid_d;
      phase_q     <= phase_d;
      res_valid_q <= res_valid_d;
      mod_q       <= mod_d;
      slots_q     <= slots_d;
      media_q     <= media_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
    res_q <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

### rtl/hkrb_key_unit.sv
module hkrb_key_unit #(
  parameter int KeySlots = hkrb_pkg::KeySlotsDefault
) (
  input  logic       pressing_i,
  input  logic [7:0] code_i,
  input  logic [7:0] mod_i,
  input  logic [7:0] slots_i [KeySlots],
  output logic [7:0] mod_o,
  output logic [7:0] slots_o [KeySlots],
  output logic       ok_o
);

  logic [7:0] entry;
  logic [7:0] usage;
  logic [7:0] mask;
  logic       mapped;
  logic       present;
  logic       placed;

  assign entry = hkrb_pkg::AsciiUsage[code_i[6:0]];

  always_comb begin
    usage   = '0;
    mask    = '0;
    mapped  = 1'b1;
    present = 1'b0;
    placed  = 1'b0;
    mod_o   = mod_i;
    slots_o = slots_i;
    ok_o    = 1'b0;

    if (code_i >= hkrb_pkg::RawBase) begin
      usage = code_i - hkrb_pkg::RawBase;
    end else if (code_i[7]) begin
      mask = 8'd1 << code_i[2:0];
    end else if (entry == 8'd0) begin
      mapped = 1'b0;
    end else begin
      usage = {1'b0, entry[6:0]};
      if (entry[7]) begin
        mask = hkrb_pkg::LeftShift;
      end
    end

    if (mapped) begin
      mod_o = pressing_i ? (mod_i | mask) : (mod_i & ~mask);
      if (pressing_i) begin
        // A zero usage matches any empty slot, so it is stored nowhere.
        for (int i = 0; i < KeySlots; i++) begin
          if (slots_i[i] == usage) begin
            present = 1'b1;
          end
        end
        if (!present) begin
          for (int i = 0; i < KeySlots; i++) begin
            if (!placed && slots_i[i] == 8'd0) begin
              slots_o[i] = usage;
              placed     = 1'b1;
            end
          end
        end
        ok_o = present || placed;
      end else begin
        if (usage != 8'd0) begin
          for (int i = 0; i < KeySlots; i++) begin
            if (slots_i[i] == usage) begin
              slots_o[i] = 8'd0;
            end
          end
        end
        ok_o = 1'b1;
      end
    end
  end

endmodule
